[src/ghn_pkg.sv]
// ----------------------------------------------------------------------------
// Heightfield normals package
// Shared constants, types and the triangle corner table of the grid.
// ----------------------------------------------------------------------------
package ghn_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int STORE_DEPTH = (MAX_ROWS + 1) * (MAX_COLS + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIM_W       = 7;
   localparam int HEIGHT_W    = 24;
   localparam int VEC_W       = 35;
   localparam int RES_W       = 32;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_MODE  = 2'd2;
   localparam logic [1:0] REG_WIDTH = 2'd3;

   typedef struct packed {
      logic di;
      logic dj;
   } corner_type;

   typedef struct packed {
      logic start;
      logic final_pass;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   function automatic corner_type corner(input logic mode, input logic tri_sel,
                                         input logic [1:0] k);
      corner_type c;
      c = '{di: 1'b0, dj: 1'b0};
      case ({mode, tri_sel, k})
         4'b0001: c = '{di: 1'b1, dj: 1'b1};
         4'b0010: c = '{di: 1'b1, dj: 1'b0};
         4'b0101: c = '{di: 1'b0, dj: 1'b1};
         4'b0110: c = '{di: 1'b1, dj: 1'b1};
         4'b1001: c = '{di: 1'b1, dj: 1'b0};
         4'b1010: c = '{di: 1'b1, dj: 1'b1};
         4'b1101: c = '{di: 1'b1, dj: 1'b1};
         4'b1110: c = '{di: 1'b0, dj: 1'b1};
         default: c = '{di: 1'b0, dj: 1'b0};
      endcase
      return c;
   endfunction

endpackage

[src/ghn_store.sv]
// ----------------------------------------------------------------------------
// Height store
// One write port and one registered read port over all grid vertices.
// ----------------------------------------------------------------------------
module ghn_store (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [ghn_pkg::ADDR_W-1:0]             wr_addr,
   input  logic signed [ghn_pkg::HEIGHT_W-1:0]    wr_data,
   input  logic [ghn_pkg::ADDR_W-1:0]             rd_addr,
   output logic signed [ghn_pkg::HEIGHT_W-1:0]    rd_data
);

   logic signed [ghn_pkg::HEIGHT_W-1:0] mem [ghn_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[src/ghn_unit.sv]
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a vector to unit length with one shift, square, square root and divide datapath.
// ----------------------------------------------------------------------------
module ghn_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  ghn_pkg::unit_cmd_type               cmd,
   input  logic signed [ghn_pkg::VEC_W-1:0]    vec [3],
   output ghn_pkg::unit_sts_type               sts,
   output logic signed [ghn_pkg::RES_W-1:0]    res [3]
);

   typedef enum logic [6:0] {
      U_IDLE = 7'b0000001,
      U_NORM = 7'b0000010,
      U_SQ   = 7'b0000100,
      U_SQRT = 7'b0001000,
      U_DSET = 7'b0010000,
      U_DIV  = 7'b0100000,
      U_DONE = 7'b1000000
   } ustate_type;

   ustate_type state_ff, state_in;
   logic [ghn_pkg::VEC_W-1:0] mag_ff [3];
   logic [ghn_pkg::VEC_W-1:0] mag_in [3];
   logic [2:0]  neg_ff, neg_in;
   logic        fin_ff, fin_in;
   logic [41:0] sum_ff, sum_in;
   logic [63:0] x_ff, x_in, root_ff, root_in, bit_ff, bit_in;
   logic [31:0] rem_ff, rem_in, lo_ff, lo_in, quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  k_ff, k_in;
   logic signed [ghn_pkg::RES_W-1:0] res_ff [3];
   logic signed [ghn_pkg::RES_W-1:0] res_in [3];

   logic [ghn_pkg::VEC_W-1:0] m_max;
   logic [19:0] mag_k;
   logic [39:0] prod;
   logic [63:0] rb;
   logic [60:0] num;
   logic [32:0] trial;
   logic [31:0] cap, qcap;

   always_comb begin
      m_max = mag_ff[0];
      if (mag_ff[1] > m_max) m_max = mag_ff[1];
      if (mag_ff[2] > m_max) m_max = mag_ff[2];
      mag_k = mag_ff[k_ff][19:0];
      prod  = 40'(mag_k) * 40'(mag_k);
      rb    = root_ff + bit_ff;
      num   = (fin_ff ? (61'(mag_k) << 24) : (61'(mag_k) << 40)) + 61'(root_ff[31:1]);
      trial = {rem_ff, lo_ff[31]};
      cap   = fin_ff ? (32'd1 << 14) : (32'd1 << 30);
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      fin_in   = fin_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      res_in   = res_ff;
      qcap     = '0;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vec[i][ghn_pkg::VEC_W-1];
                  mag_in[i] = vec[i][ghn_pkg::VEC_W-1] ? ghn_pkg::VEC_W'(-vec[i])
                                                       : ghn_pkg::VEC_W'(vec[i]);
               end
               fin_in   = cmd.final_pass;
               state_in = U_NORM;
            end
         end
         U_NORM: begin
            if (m_max == '0) begin
               res_in[0] = '0;
               res_in[1] = signed'(cap);
               res_in[2] = '0;
               state_in  = U_DONE;
            end else if (m_max >= (ghn_pkg::VEC_W'(1) << 20)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (m_max < (ghn_pkg::VEC_W'(1) << 19)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               sum_in   = '0;
               k_in     = '0;
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            sum_in = sum_ff + 42'(prod);
            if (k_ff == 2'd2) begin
               state_in = U_SQRT;
               k_in     = '0;
               cnt_in   = '0;
               root_in  = '0;
               bit_in   = 64'd1 << 62;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         U_SQRT: begin
            if (cnt_ff == 5'd0 && bit_ff == (64'd1 << 62)) begin
               x_in = 64'(sum_ff) << 20;
            end
            if (((cnt_ff == 5'd0) ? (64'(sum_ff) << 20) : x_ff) >= rb) begin
               x_in    = ((cnt_ff == 5'd0) ? (64'(sum_ff) << 20) : x_ff) - rb;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               cnt_in   = '0;
               state_in = U_DSET;
            end
         end
         U_DSET: begin
            rem_in   = 32'(num[60:32]);
            lo_in    = num[31:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            if (trial >= 33'(root_ff[31:0])) begin
               rem_in = 32'(trial - 33'(root_ff[31:0]));
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            lo_in  = lo_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               qcap = (quo_in > cap) ? cap : quo_in;
               res_in[k_ff] = neg_ff[k_ff] ? -signed'(qcap) : signed'(qcap);
               if (k_ff == 2'd2) begin
                  state_in = U_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = U_DSET;
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      fin_ff  <= fin_in;
      sum_ff  <= sum_in;
      x_ff    <= x_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      res_ff  <= res_in;
   end

   assign sts.busy = (state_ff != U_IDLE);
   assign sts.done = (state_ff == U_DONE);
   assign res      = res_ff;

endmodule

[src/grid_heightfield_normals.sv]
// ----------------------------------------------------------------------------
// Heightfield grid vertex normals
// Stores grid heights and answers reads with the smoothed vertex normal.
// ----------------------------------------------------------------------------
// A read is a row search, then one normalization in the shared unit (a 32-step
// square root and three 32-step divisions) for each adjacent triangle (up to
// six) and one more for the final sum.
// Reset restores the register defaults; the height memory is not cleared.
// ----------------------------------------------------------------------------
module grid_heightfield_normals (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // vertex_number, height, zero fill
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // normal_x, normal_y, normal_z, vertex_echo, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIVV  = 9'b000000010,
      S_QUAD  = 9'b000000100,
      S_FETCH = 9'b000001000,
      S_FACE  = 9'b000010000,
      S_UNIT  = 9'b000100000,
      S_FINAL = 9'b001000000,
      S_WFIN  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic        mode_ff, mode_in;
   logic [15:0] width_ff, width_in;
   logic [12:0] vn_ff, vn_in, rem_ff, rem_in;
   logic [6:0]  vi_ff, vi_in, vj_ff, vj_in;
   logic [3:0]  tri_ff, tri_in;
   logic [1:0]  fk_ff, fk_in;
   logic signed [ghn_pkg::HEIGHT_W-1:0] h_ff [3];
   logic signed [ghn_pkg::HEIGHT_W-1:0] h_in [3];
   logic signed [ghn_pkg::VEC_W-1:0] acc_ff [3];
   logic signed [ghn_pkg::VEC_W-1:0] acc_in [3];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [6:0]  rows_c, cols_c;
   logic [15:0] w_c;
   logic [12:0] count_c, cols1;
   logic [12:0] req_vn;
   logic        req_fire, in_range;
   logic        oi, oj, tsel, quad_ok, touches;
   ghn_pkg::corner_type fc, c0, c1, c2;
   logic [7:0]  row8, col8;
   logic [ghn_pkg::ADDR_W-1:0] rd_addr;
   logic signed [ghn_pkg::HEIGHT_W-1:0] rd_data;
   logic signed [24:0] ey0, ey1;
   logic signed [2:0]  ex0, ex1, ez0, ez1, dz0, dz1;
   logic signed [3:0]  cw;
   logic signed [ghn_pkg::VEC_W-1:0] face [3];
   logic signed [ghn_pkg::VEC_W-1:0] unit_vec [3];
   logic signed [ghn_pkg::RES_W-1:0] unit_res [3];
   ghn_pkg::unit_cmd_type unit_cmd;
   ghn_pkg::unit_sts_type unit_sts;

   function automatic logic signed [ghn_pkg::VEC_W-1:0] sel_mul(
      input logic signed [24:0] a, input logic signed [2:0] s);
      logic signed [ghn_pkg::VEC_W-1:0] r;
      r = '0;
      if (s == 3'sd1) r = ghn_pkg::VEC_W'(a);
      else if (s == -3'sd1) r = -ghn_pkg::VEC_W'(a);
      return r;
   endfunction

   assign rows_c  = (rows_ff == '0) ? 7'd1 :
                    (rows_ff > 7'(ghn_pkg::MAX_ROWS)) ? 7'(ghn_pkg::MAX_ROWS) : rows_ff;
   assign cols_c  = (cols_ff == '0) ? 7'd1 :
                    (cols_ff > 7'(ghn_pkg::MAX_COLS)) ? 7'(ghn_pkg::MAX_COLS) : cols_ff;
   assign w_c     = (width_ff == '0) ? 16'd1 : width_ff;
   assign cols1   = 13'(cols_c) + 13'd1;
   assign count_c = 13'((16'(rows_c) + 16'd1) * (16'(cols_c) + 16'd1));
   assign req_vn  = req_tdata[12:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = (req_vn < count_c);
   assign csr_ready  = 1'b1;

   assign oi   = tri_ff[2];
   assign oj   = tri_ff[1];
   assign tsel = tri_ff[0];
   assign c0   = ghn_pkg::corner(mode_ff, tsel, 2'd0);
   assign c1   = ghn_pkg::corner(mode_ff, tsel, 2'd1);
   assign c2   = ghn_pkg::corner(mode_ff, tsel, 2'd2);
   assign fc   = ghn_pkg::corner(mode_ff, tsel, fk_ff);
   assign quad_ok = (oi ? (vi_ff < rows_c) : (vi_ff != '0)) &&
                    (oj ? (vj_ff < cols_c) : (vj_ff != '0));
   assign touches = ((oi ^ c0.di) && (oj ^ c0.dj)) || ((oi ^ c1.di) && (oj ^ c1.dj)) ||
                    ((oi ^ c2.di) && (oj ^ c2.dj));

   assign row8    = 8'(vi_ff) + 8'(oi) + 8'(fc.di) - 8'd1;
   assign col8    = 8'(vj_ff) + 8'(oj) + 8'(fc.dj) - 8'd1;
   assign rd_addr = ghn_pkg::ADDR_W'(16'(row8[6:0]) * (16'(cols_c) + 16'd1)) +
                    ghn_pkg::ADDR_W'(col8[6:0]);

   always_comb begin
      ey0 = 25'(h_ff[1]) - 25'(h_ff[0]);
      ey1 = 25'(h_ff[2]) - 25'(h_ff[0]);
      ex0 = signed'({2'b00, c1.dj}) - signed'({2'b00, c0.dj});
      ex1 = signed'({2'b00, c2.dj}) - signed'({2'b00, c0.dj});
      dz0 = signed'({2'b00, c1.di}) - signed'({2'b00, c0.di});
      dz1 = signed'({2'b00, c2.di}) - signed'({2'b00, c0.di});
      ez0 = mode_ff ? dz0 : -dz0;
      ez1 = mode_ff ? dz1 : -dz1;
      cw  = 4'(ez0 * ex1) - 4'(ex0 * ez1);
      face[0] = sel_mul(ey0, ez1) - sel_mul(ey1, ez0);
      face[2] = sel_mul(ey1, ex0) - sel_mul(ey0, ex1);
      case (cw)
         4'sd1:   face[1] = ghn_pkg::VEC_W'(w_c);
         -4'sd1:  face[1] = -ghn_pkg::VEC_W'(w_c);
         4'sd2:   face[1] = ghn_pkg::VEC_W'(w_c) <<< 1;
         -4'sd2:  face[1] = -(ghn_pkg::VEC_W'(w_c) <<< 1);
         default: face[1] = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit_vec[i] = (state_ff == S_FINAL) ? acc_ff[i] : face[i];
      end
   end

   assign unit_cmd.start      = (state_ff == S_FACE) || (state_ff == S_FINAL);
   assign unit_cmd.final_pass = (state_ff == S_FINAL);

   ghn_store u_store (
      .clock   (clock),
      .wr_en   (req_fire && in_range && req_tuser == ghn_pkg::KIND_WRITE),
      .wr_addr (ghn_pkg::ADDR_W'(req_vn)),
      .wr_data (signed'(req_tdata[36:13])),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ghn_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .vec   (unit_vec),
      .sts   (unit_sts),
      .res   (unit_res)
   );

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      mode_in  = mode_ff;
      width_in = width_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ghn_pkg::REG_ROWS:  rows_in  = csr_data[6:0];
            ghn_pkg::REG_COLS:  cols_in  = csr_data[6:0];
            ghn_pkg::REG_MODE:  mode_in  = csr_data[0];
            ghn_pkg::REG_WIDTH: width_in = csr_data;
            default:            rows_in  = rows_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      vn_in        = vn_ff;
      rem_in       = rem_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      tri_in       = tri_ff;
      fk_in        = fk_ff;
      h_in         = h_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && in_range && req_tuser == ghn_pkg::KIND_READ) begin
               vn_in    = req_vn;
               rem_in   = req_vn;
               vi_in    = '0;
               state_in = S_DIVV;
            end
         end
         S_DIVV: begin
            if (rem_ff >= cols1) begin
               rem_in = rem_ff - cols1;
               vi_in  = vi_ff + 7'd1;
            end else begin
               vj_in    = rem_ff[6:0];
               tri_in   = '0;
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               state_in = S_QUAD;
            end
         end
         S_QUAD: begin
            if (tri_ff[3]) begin
               state_in = S_FINAL;
            end else if (quad_ok && touches) begin
               fk_in    = '0;
               state_in = S_FETCH;
            end else begin
               tri_in = tri_ff + 4'd1;
            end
         end
         S_FETCH: begin
            if (fk_ff != 2'd0) h_in[fk_ff - 2'd1] = rd_data;
            fk_in = fk_ff + 2'd1;
            if (fk_ff == 2'd3) state_in = S_FACE;
         end
         S_FACE: begin
            state_in = S_UNIT;
         end
         S_UNIT: begin
            if (unit_sts.done) begin
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = acc_ff[i] + ghn_pkg::VEC_W'(unit_res[i]);
               end
               tri_in   = tri_ff + 4'd1;
               state_in = S_QUAD;
            end
         end
         S_FINAL: begin
            state_in = S_WFIN;
         end
         S_WFIN: begin
            if (unit_sts.done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, vn_ff, unit_res[2][15:0], unit_res[1][15:0],
                               unit_res[0][15:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= 7'd3;
         cols_ff      <= 7'd4;
         mode_ff      <= 1'b0;
         width_ff     <= 16'd256;
         rsp_valid_ff <= 1'b0;
         tri_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         mode_ff      <= mode_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
         tri_ff       <= tri_in;
      end
      vn_ff       <= vn_in;
      rem_ff      <= rem_in;
      vi_ff       <= vi_in;
      vj_ff       <= vj_in;
      fk_ff       <= fk_in;
      h_ff        <= h_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == S_UNIT || state_ff == S_WFIN))
      else $error("normalizer finished while no result was awaited");

   a_fetch_to_face: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH && fk_ff == 2'd3) |=> (state_ff == S_FACE))
      else $error("height fetch did not end in face computation");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output state");

   a_tri_bound: assert property (@(posedge clock) disable iff (reset)
      tri_ff <= 4'd8)
      else $error("triangle counter ran past the last triangle");
`endif

endmodule

[sim/grid_heightfield_normals_test.sv]
// ----------------------------------------------------------------------------
// Heightfield normals testbench
// Drives height writes and normal reads through several grid settings, with
// random idle and stall patterns, and checks every normal against a predictor.
// ----------------------------------------------------------------------------
module grid_heightfield_normals_test;

   typedef longint vec3_type [3];

   typedef struct {
      logic        kind;
      logic [12:0] vertex;
      logic [23:0] height;
   } grid_op_type;

   typedef struct {
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic [12:0] vertex;
   } normal_type;

   localparam int CORNER_DI [2][2][3] = '{'{'{0, 1, 1}, '{0, 0, 1}},
                                          '{'{0, 1, 1}, '{0, 1, 0}}};
   localparam int CORNER_DJ [2][2][3] = '{'{'{0, 1, 0}, '{0, 1, 1}},
                                          '{'{0, 0, 1}, '{0, 1, 1}}};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   grid_op_type     pending_ops[$];
   normal_type      expected_normals[$];
   grid_op_type     current_op;
   bit signed [23:0] heights [ghn_pkg::STORE_DEPTH];
   bit              planned_written [ghn_pkg::STORE_DEPTH];
   logic [6:0]      rows_cfg = 7'd3;
   logic [6:0]      cols_cfg = 7'd4;
   logic            mode_cfg = 1'b0;
   logic [15:0]     width_cfg = 16'd256;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              fail_count = 0;

   grid_heightfield_normals DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic int grid_rows();
      return rows_cfg < 1 ? 1 :
             (rows_cfg > ghn_pkg::MAX_ROWS ? ghn_pkg::MAX_ROWS : int'(rows_cfg));
   endfunction

   function automatic int grid_cols();
      return cols_cfg < 1 ? 1 :
             (cols_cfg > ghn_pkg::MAX_COLS ? ghn_pkg::MAX_COLS : int'(cols_cfg));
   endfunction

   function automatic int vertex_count();
      return (grid_rows() + 1) * (grid_cols() + 1);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic vec3_type unitize_vec(input vec3_type v, input int frac);
      longint unsigned mag [3];
      longint unsigned m, s, len, q, cap;
      vec3_type r;
      m = 0;
      s = 0;
      cap = 64'd1 << frac;
      for (int k = 0; k < 3; k++) begin
         mag[k] = v[k] < 0 ? longint'(-v[k]) : longint'(v[k]);
         if (mag[k] > m) m = mag[k];
      end
      if (m == 0) begin
         r = '{0, longint'(cap), 0};
         return r;
      end
      while (m >= (64'd1 << 20)) begin
         for (int k = 0; k < 3; k++) mag[k] >>= 1;
         m >>= 1;
      end
      while (m < (64'd1 << 19)) begin
         for (int k = 0; k < 3; k++) mag[k] <<= 1;
         m <<= 1;
      end
      for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
      len = int_sqrt(s << 20);
      for (int k = 0; k < 3; k++) begin
         q = ((mag[k] << (frac + 10)) + (len >> 1)) / len;
         if (q > cap) q = cap;
         r[k] = v[k] < 0 ? -longint'(q) : longint'(q);
      end
      return r;
   endfunction

   function automatic normal_type vertex_normal(input int vn);
      int rows, cols, vi, vj, mode, zsign, di, dj;
      longint w, ex0, ey0, ez0, ex1, ey1, ez1;
      longint gx [3], gz [3], hh [3];
      vec3_type acc, face, unit_face, res;
      bit touches;
      normal_type n;
      rows = grid_rows();
      cols = grid_cols();
      w = width_cfg == 0 ? 1 : longint'(width_cfg);
      vi = vn / (cols + 1);
      vj = vn % (cols + 1);
      mode = mode_cfg;
      zsign = mode == 0 ? -1 : 1;
      acc = '{0, 0, 0};
      for (int qi = vi - 1; qi <= vi; qi++) begin
         for (int qj = vj - 1; qj <= vj; qj++) begin
            if (qi < 0 || qi >= rows || qj < 0 || qj >= cols) continue;
            for (int t = 0; t < 2; t++) begin
               touches = 0;
               for (int k = 0; k < 3; k++) begin
                  di = CORNER_DI[mode][t][k];
                  dj = CORNER_DJ[mode][t][k];
                  if (qi + di == vi && qj + dj == vj) touches = 1;
                  gx[k] = dj;
                  gz[k] = zsign * di;
                  hh[k] = longint'(heights[(qi + di) * (cols + 1) + qj + dj]);
               end
               if (!touches) continue;
               ex0 = gx[1] - gx[0]; ey0 = hh[1] - hh[0]; ez0 = gz[1] - gz[0];
               ex1 = gx[2] - gx[0]; ey1 = hh[2] - hh[0]; ez1 = gz[2] - gz[0];
               face[0] = ey0 * ez1 - ez0 * ey1;
               face[1] = w * (ez0 * ex1 - ex0 * ez1);
               face[2] = ex0 * ey1 - ey0 * ex1;
               unit_face = unitize_vec(face, 30);
               for (int k = 0; k < 3; k++) acc[k] += unit_face[k];
            end
         end
      end
      res = unitize_vec(acc, 14);
      n.nx = 16'(res[0]);
      n.ny = 16'(res[1]);
      n.nz = 16'(res[2]);
      n.vertex = 13'(vn);
      return n;
   endfunction

   function automatic logic [23:0] random_height();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'($urandom_range(2047)) - 24'd1024;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic plan_write(input int vn, input logic [23:0] h);
      pending_ops.push_back('{kind: ghn_pkg::KIND_WRITE, vertex: 13'(vn), height: h});
      if (vn < vertex_count()) planned_written[vn] = 1;
   endtask

   // A read is queued only after every vertex around it holds a height.
   task automatic plan_read(input int vn);
      int cols, rows, vi, vj;
      cols = grid_cols();
      rows = grid_rows();
      if (vn < vertex_count()) begin
         vi = vn / (cols + 1);
         vj = vn % (cols + 1);
         for (int i = vi - 1; i <= vi + 1; i++)
            for (int j = vj - 1; j <= vj + 1; j++)
               if (i >= 0 && i <= rows && j >= 0 && j <= cols &&
                   !planned_written[i * (cols + 1) + j])
                  plan_write(i * (cols + 1) + j, random_height());
      end
      pending_ops.push_back('{kind: ghn_pkg::KIND_READ, vertex: 13'(vn),
                              height: random_height()});
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         ghn_pkg::REG_ROWS:  rows_cfg  = value[6:0];
         ghn_pkg::REG_COLS:  cols_cfg  = value[6:0];
         ghn_pkg::REG_MODE:  mode_cfg  = value[0];
         ghn_pkg::REG_WIDTH: width_cfg = value;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int rows, input int cols, input int mode,
                            input int width);
      csr_write(ghn_pkg::REG_ROWS, 16'(rows));
      csr_write(ghn_pkg::REG_COLS, 16'(cols));
      csr_write(ghn_pkg::REG_MODE, 16'(mode));
      csr_write(ghn_pkg::REG_WIDTH, 16'(width));
   endtask

   task automatic drain();
      while (pending_ops.size() != 0 || req_tvalid || expected_normals.size() != 0)
         @(posedge clock);
      repeat (1500) @(posedge clock);
   endtask

   task automatic random_traffic(input int actions);
      int count, pick;
      count = vertex_count();
      for (int a = 0; a < actions; a++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            plan_read($urandom_range(count - 1));
         else if (pick < 85)
            plan_write($urandom_range(count - 1), random_height());
         else if (pick < 92)
            plan_write($urandom_range(8191, count), random_height());
         else
            plan_read($urandom_range(8191, count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready && current_op.vertex < vertex_count()) begin
            if (current_op.kind == ghn_pkg::KIND_WRITE)
               heights[current_op.vertex] = current_op.height;
            else
               expected_normals.push_back(vertex_normal(current_op.vertex));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               current_op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= current_op.kind;
               req_tdata  <= {3'b0, current_op.height, current_op.vertex};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      normal_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_normals.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = expected_normals.pop_front();
               if (rsp_tdata[15:0] !== want.nx)
                  report_mismatch($sformatf("vertex %0d normal_x %h, expected %h",
                                            want.vertex, rsp_tdata[15:0], want.nx));
               if (rsp_tdata[31:16] !== want.ny)
                  report_mismatch($sformatf("vertex %0d normal_y %h, expected %h",
                                            want.vertex, rsp_tdata[31:16], want.ny));
               if (rsp_tdata[47:32] !== want.nz)
                  report_mismatch($sformatf("vertex %0d normal_z %h, expected %h",
                                            want.vertex, rsp_tdata[47:32], want.nz));
               if (rsp_tdata[60:48] !== want.vertex)
                  report_mismatch($sformatf("vertex_echo %0d, expected %0d",
                                            rsp_tdata[60:48], want.vertex));
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ghn_pkg::KIND_WRITE;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = ghn_pkg::REG_ROWS;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset grid of 4 x 5 vertices.
      for (int v = 0; v < 20; v++)
         plan_write(v, v[0] ? 24'h7FFFFF : 24'h800000);
      plan_read(0);
      plan_read(4);
      plan_read(15);
      plan_read(19);
      plan_read(7);
      plan_read(5);
      plan_write(20, 24'h123456);
      plan_read(20);
      plan_read(8191);
      plan_write(8191, 24'h555555);
      for (int v = 0; v < 20; v++) plan_write(v, 24'h000100);
      plan_read(12);
      plan_read(9);
      drain();

      for (int phase = 1; phase <= 8; phase++) begin
         case (phase)
            1: configure(1, 1, 1, 1);
            2: configure(64, 64, 0, 65535);
            3: configure(0, 127, 1, 0);
            4: configure(64, 1, 0, $urandom_range(65535));
            5: configure(5, 3, 1, 256);
            default: configure($urandom_range(1, 8), $urandom_range(1, 8),
                               $urandom_range(1), $urandom_range(1, 65535));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         random_traffic(phase == 2 ? 60 : 120);
         drain();
      end

      if (expected_normals.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_normals.size()));
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
